// ===== rtl/core/huffman_tree_decoder_top_assert.svh =====
// Assertion macros for the code tree decoder.
`ifndef HUFFMAN_TREE_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HUFD_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HUFD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hufd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared constants and the queue entry type of the code tree decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int MAX_NODES_DEF = 128;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic FUNC_TREE = 1'b0;
    localparam logic FUNC_CODE = 1'b1;

    // The queue depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
        logic       is_open;
        logic       is_close;
        logic       is_zero;
        logic       is_sep;
    } item_t;

endpackage

// ===== rtl/core/hufd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_front
// Accepts input transactions, classifies the character and queues the result.
// ----------------------------------------------------------------------------
module hufd_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_func,
    input  logic [7:0]     in_char,
    output logic           q_valid,
    input  logic           q_ready,
    output hufd_pkg::item_t q_item
);

    hufd_pkg::item_t                    mem_reg [hufd_pkg::QUEUE_DEPTH];
    logic [hufd_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [hufd_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [hufd_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [hufd_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [hufd_pkg::QCNT_W-1:0]        count_reg;
    logic [hufd_pkg::QCNT_W-1:0]        count_next;
    hufd_pkg::item_t                    cls;
    logic                               push;
    logic                               pop;

    always_comb
    begin
        cls.func     = in_func;
        cls.ch       = in_char;
        cls.is_open  = (in_func == hufd_pkg::FUNC_TREE) && (in_char == hufd_pkg::CH_OPEN);
        cls.is_close = (in_func == hufd_pkg::FUNC_TREE) && (in_char == hufd_pkg::CH_CLOSE);
        cls.is_zero  = (in_func == hufd_pkg::FUNC_CODE) && (in_char == hufd_pkg::CH_ZERO);
        cls.is_sep   = (in_func == hufd_pkg::FUNC_CODE)
                       && ((in_char == hufd_pkg::CH_SPACE) || (in_char == hufd_pkg::CH_DOT));
    end

    assign in_ready = (count_reg != hufd_pkg::QCNT_W'(hufd_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + hufd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + hufd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + hufd_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - hufd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/hufd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_back
// Executes queued transactions against the node table: builds the tree and
// walks it, producing one result per code separator.
// ----------------------------------------------------------------------------
module hufd_back
#(
    parameter int MAX_NODES = hufd_pkg::MAX_NODES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  hufd_pkg::item_t q_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_symbol,
    output logic            out_error
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef enum logic [1:0]
    {
        ST_ISSUE  = 2'b01,
        ST_FINISH = 2'b10
    } state_t;

    typedef enum logic [2:0]
    {
        OP_NONE,
        OP_NEW,
        OP_UP,
        OP_STEP,
        OP_EMIT
    } op_t;

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [1:0]      cur_cv_reg, cur_cv_next;
    logic [IW-1:0]   cur_par_reg, cur_par_next;
    logic            prev_open_reg, prev_open_next;
    logic            ovf_reg, ovf_next;
    logic [IW-1:0]   walk_reg, walk_next;
    logic            werr_reg, werr_next;
    logic [IW-1:0]   nn_reg, nn_next;
    logic            zero_reg, zero_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_symbol_reg, out_symbol_next;
    logic            out_error_reg, out_error_next;

    logic [7:0]      sym_mem   [MAX_NODES];
    logic [IW-1:0]   left_mem  [MAX_NODES];
    logic [IW-1:0]   right_mem [MAX_NODES];
    logic [IW-1:0]   par_mem   [MAX_NODES];
    logic [1:0]      cv_mem    [MAX_NODES];

    logic [7:0]      sym_rd_reg;
    logic [IW-1:0]   left_rd_reg;
    logic [IW-1:0]   right_rd_reg;
    logic [IW-1:0]   par_rd_reg;
    logic [1:0]      cv_rd_reg;

    logic            sym_we;
    logic [7:0]      sym_wd;
    logic            left_we;
    logic            right_we;
    logic            par_we;
    logic [IW-1:0]   par_wd;
    logic            cv_we;
    logic [IW-1:0]   cv_wa;
    logic [1:0]      cv_wd;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;

    logic [IW-1:0]   n_idx;
    logic            full;
    logic            empty;
    logic [1:0]      link_bit;
    logic            bad;

    assign n_idx    = count_reg[IW-1:0];
    assign full     = (count_reg == CW'(MAX_NODES));
    assign empty    = (count_reg == '0);
    assign link_bit = cur_cv_reg[0] ? 2'b10 : 2'b01;
    assign bad      = werr_reg || empty;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        cur_cv_next     = cur_cv_reg;
        cur_par_next    = cur_par_reg;
        prev_open_next  = prev_open_reg;
        ovf_next        = ovf_reg;
        walk_next       = walk_reg;
        werr_next       = werr_reg;
        nn_next         = nn_reg;
        zero_next       = zero_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_symbol_next = out_symbol_reg;
        out_error_next  = out_error_reg;
        q_ready         = 1'b0;
        sym_we          = 1'b0;
        sym_wd          = q_item.ch;
        left_we         = 1'b0;
        right_we        = 1'b0;
        par_we          = 1'b0;
        par_wd          = empty ? '0 : cur_reg;
        cv_we           = 1'b0;
        cv_wa           = cur_reg;
        cv_wd           = cur_cv_reg | link_bit;
        rd_en           = 1'b0;
        rd_addr         = walk_reg;

        case (state_reg)
            ST_ISSUE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = ST_FINISH;
                    op_next    = OP_NONE;
                    zero_next  = q_item.is_zero;
                    if (q_item.func == hufd_pkg::FUNC_TREE)
                    begin
                        prev_open_next = q_item.is_open;
                        if (prev_open_reg && !full)
                        begin
                            sym_we     = 1'b1;
                            par_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            nn_next    = n_idx;
                            op_next    = OP_NEW;
                            if (!empty)
                            begin
                                cv_we    = 1'b1;
                                left_we  = !cur_cv_reg[0];
                                right_we = cur_cv_reg[0];
                            end
                            if (q_item.is_close)
                            begin
                                if (empty)
                                begin
                                    cur_next     = '0;
                                    cur_cv_next  = '0;
                                    cur_par_next = '0;
                                end
                                else
                                begin
                                    cur_cv_next = cur_cv_reg | link_bit;
                                end
                            end
                            else
                            begin
                                cur_next     = n_idx;
                                cur_cv_next  = '0;
                                cur_par_next = empty ? '0 : cur_reg;
                            end
                        end
                        else
                        begin
                            if (prev_open_reg)
                            begin
                                ovf_next = 1'b1;
                            end
                            if (q_item.is_close && !empty)
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = cur_par_reg;
                                cur_next = cur_par_reg;
                                op_next  = OP_UP;
                            end
                        end
                    end
                    else if (q_item.is_sep)
                    begin
                        rd_en   = 1'b1;
                        op_next = OP_EMIT;
                    end
                    else if (!werr_reg)
                    begin
                        if (empty)
                        begin
                            werr_next = 1'b1;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            op_next = OP_STEP;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                state_next = ST_ISSUE;
                case (op_reg)
                    OP_NEW:
                    begin
                        cv_we = 1'b1;
                        cv_wa = nn_reg;
                        cv_wd = '0;
                    end
                    OP_UP:
                    begin
                        cur_cv_next  = cv_rd_reg;
                        cur_par_next = par_rd_reg;
                    end
                    OP_STEP:
                    begin
                        if (zero_reg)
                        begin
                            if (cv_rd_reg[0])
                            begin
                                walk_next = left_rd_reg;
                            end
                            else
                            begin
                                werr_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (cv_rd_reg[1])
                            begin
                                walk_next = right_rd_reg;
                            end
                            else
                            begin
                                werr_next = 1'b1;
                            end
                        end
                    end
                    OP_EMIT:
                    begin
                        if (!out_valid_reg || out_ready)
                        begin
                            out_valid_next  = 1'b1;
                            out_symbol_next = bad ? 8'h00 : sym_rd_reg;
                            out_error_next  = bad || ovf_reg;
                            walk_next       = '0;
                            werr_next       = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_ISSUE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_ISSUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ISSUE;
            op_reg        <= OP_NONE;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_cv_reg    <= '0;
            cur_par_reg   <= '0;
            prev_open_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            walk_reg      <= '0;
            werr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cur_cv_reg    <= cur_cv_next;
            cur_par_reg   <= cur_par_next;
            prev_open_reg <= prev_open_next;
            ovf_reg       <= ovf_next;
            walk_reg      <= walk_next;
            werr_reg      <= werr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nn_reg         <= nn_next;
        zero_reg       <= zero_next;
        out_symbol_reg <= out_symbol_next;
        out_error_reg  <= out_error_next;
    end

    always_ff @(posedge clk)
    begin
        if (sym_we)
        begin
            sym_mem[n_idx] <= sym_wd;
        end
        if (rd_en)
        begin
            sym_rd_reg <= sym_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[cur_reg] <= n_idx;
        end
        if (rd_en)
        begin
            left_rd_reg <= left_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[cur_reg] <= n_idx;
        end
        if (rd_en)
        begin
            right_rd_reg <= right_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[n_idx] <= par_wd;
        end
        if (rd_en)
        begin
            par_rd_reg <= par_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv_we)
        begin
            cv_mem[cv_wa] <= cv_wd;
        end
        if (rd_en)
        begin
            cv_rd_reg <= cv_mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_error  = out_error_reg;

endmodule

// ===== rtl/core/huffman_tree_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// Builds a binary code tree from tree text and decodes a bit stream with it.
//
// Channel   Dir  Payload
// s_axis    in   tdata = char_in[7:0], tuser = func
// m_axis    out  tdata = symbol_out[7:0], tuser = error_flag
//
// Each transaction passes through ST_ISSUE, which issues the node table read,
// and ST_FINISH, which uses the registered read data; a new transaction is
// taken only when the last is through. A two-entry queue decouples input
// acceptance from execution, and a full output register stalls only a
// separator. Reset clears control state only; the node table needs no clear.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_top_assert.svh"

module huffman_tree_decoder_top
#(
    parameter int MAX_NODES = hufd_pkg::MAX_NODES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] symbol_out
    output logic       m_axis_tuser    // [0] error_flag
);

    logic            q_valid;
    logic            q_ready;
    logic            q_pop;
    hufd_pkg::item_t q_item;

    hufd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser),
        .in_char  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    hufd_back
    #(
        .MAX_NODES (MAX_NODES)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_symbol (m_axis_tdata),
        .out_error  (m_axis_tuser)
    );

    assign q_pop = q_valid && q_ready;

    `HUFD_ASSERT_NEXT(a_pop_spacing, clk, rst_n, q_pop, !q_pop, "queue popped in consecutive cycles")
    `HUFD_ASSERT_IMPL(a_emit_source, clk, rst_n, $rose(m_axis_tvalid), $past(q_pop, 2), "result without a transaction two cycles earlier")

endmodule
